[design/midpoint_ellipse_rasterizer_assert.svh]
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer assertion macros
// Concurrent assertion wrappers sampled on clk_i, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_ASSERT_SVH

// Same-cycle implication.
`define MER_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("midpoint ellipse rasterizer: assertion failed");

// Next-cycle implication.
`define MER_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("midpoint ellipse rasterizer: assertion failed");

`endif

[design/mer_pkg.sv]
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer package
// Widths, register indexes, controller states and command/status types.
// ----------------------------------------------------------------------------
`default_nettype none

package mer_pkg;

  localparam int COORD_BITS = 10;
  localparam int PT_W       = COORD_BITS + 1;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int MUL_W      = 2 * COORD_BITS + 2;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int GRAD_W     = 3 * COORD_BITS + 4;
  localparam int DEC_W      = 4 * COORD_BITS + 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = COORD_BITS;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_A = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_B = 1'b1;

  // Point index of the final mirrored copy, on an axis and off it.
  localparam logic [1:0] PT_LAST_SHORT = 2'd1;
  localparam logic [1:0] PT_LAST_FULL  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_R0,
    ST_R1,
    ST_R2,
    ST_R3,
    ST_CHECK,
    ST_W0,
    ST_W1,
    ST_W2,
    ST_W3,
    ST_W4,
    ST_W5,
    ST_EMIT,
    ST_STEP,
    ST_FIN
  } mer_state_e;

  typedef enum logic [2:0] {
    MUL_AA,
    MUL_BB,
    MUL_ASQ_B,
    MUL_TX_TX,
    MUL_TY_TY,
    MUL_BSQ_T1,
    MUL_ASQ_T2,
    MUL_ASQ_BSQ
  } mer_mul_e;

  typedef enum logic [3:0] {
    WR_NONE,
    WR_ASQ,
    WR_BSQ,
    WR_INIT,
    WR_T1,
    WR_T2,
    WR_DEC_SET,
    WR_DEC_ADD4,
    WR_DEC_SUB4
  } mer_wr_e;

  typedef struct packed {
    mer_mul_e   mul_sel;
    mer_wr_e    wr_sel;
    logic       step1;
    logic       step2;
    logic       load_pt;
    logic       load_fin;
    logic [1:0] pt_idx;
    logic       pt_last;
  } mer_cmd_t;

  typedef struct packed {
    logic done;
    logic to_region_two;
    logic pt_short;
    logic out_free;
  } mer_stat_t;

endpackage

`default_nettype wire

[design/mer_in_if.sv]
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer request channel
// Valid/ready channel carrying the restart flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface mer_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

`default_nettype wire

[design/mer_out_if.sv]
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer result channel
// Valid/ready channel carrying one ellipse point or the finished marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface mer_out_if;
  import mer_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [PT_W-1:0] point_x;
  logic signed [PT_W-1:0] point_y;
  logic                   last_of_step;
  logic                   finished;

  modport source (output valid, output point_x, output point_y, output last_of_step,
                  output finished, input ready);
  modport sink (input valid, input point_x, input point_y, input last_of_step,
                input finished, output ready);
endinterface

`default_nettype wire

[design/mer_ctrl.sv]
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer controller
// Sequences restart, region switch, point emission, walk step and finished result.
// ----------------------------------------------------------------------------
`default_nettype none

module mer_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  input  wire                 restart_i,
  output logic                in_ready_o,
  input  mer_pkg::mer_stat_t  stat_i,
  output mer_pkg::mer_cmd_t   cmd_o
);
  import mer_pkg::*;

  mer_state_e state_q, state_d;
  logic [1:0] k_q, k_d;
  logic       pt_last;
  mer_state_e dispatch;

  assign pt_last = (k_q == PT_LAST_FULL) || ((k_q == PT_LAST_SHORT) && stat_i.pt_short);
  assign dispatch = stat_i.done ? ST_FIN : (stat_i.to_region_two ? ST_W0 : ST_EMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= 2'd0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = restart_i ? ST_R0 : dispatch;
        end
      end
      ST_R0:    state_d = ST_R1;
      ST_R1:    state_d = ST_R2;
      ST_R2:    state_d = ST_R3;
      ST_R3:    state_d = ST_CHECK;
      ST_CHECK: state_d = dispatch;
      ST_W0:    state_d = ST_W1;
      ST_W1:    state_d = ST_W2;
      ST_W2:    state_d = ST_W3;
      ST_W3:    state_d = ST_W4;
      ST_W4:    state_d = ST_W5;
      ST_W5:    state_d = ST_EMIT;
      ST_EMIT: begin
        if (stat_i.out_free) begin
          if (pt_last) begin
            state_d = ST_STEP;
            k_d     = 2'd0;
          end else begin
            k_d = k_q + 2'd1;
          end
        end
      end
      ST_STEP:  state_d = ST_IDLE;
      ST_FIN: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.mul_sel  = MUL_AA;
    cmd_o.wr_sel   = WR_NONE;
    cmd_o.pt_idx   = k_q;
    cmd_o.pt_last  = pt_last;
    case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_R0:    cmd_o.mul_sel = MUL_AA;
      ST_R1: begin
        cmd_o.mul_sel = MUL_BB;
        cmd_o.wr_sel  = WR_ASQ;
      end
      ST_R2: begin
        cmd_o.mul_sel = MUL_ASQ_B;
        cmd_o.wr_sel  = WR_BSQ;
      end
      ST_R3:    cmd_o.wr_sel = WR_INIT;
      ST_CHECK: cmd_o.wr_sel = WR_NONE;
      ST_W0:    cmd_o.mul_sel = MUL_TX_TX;
      ST_W1: begin
        cmd_o.mul_sel = MUL_TY_TY;
        cmd_o.wr_sel  = WR_T1;
      end
      ST_W2: begin
        cmd_o.mul_sel = MUL_BSQ_T1;
        cmd_o.wr_sel  = WR_T2;
      end
      ST_W3: begin
        cmd_o.mul_sel = MUL_ASQ_T2;
        cmd_o.wr_sel  = WR_DEC_SET;
      end
      ST_W4: begin
        cmd_o.mul_sel = MUL_ASQ_BSQ;
        cmd_o.wr_sel  = WR_DEC_ADD4;
      end
      ST_W5:    cmd_o.wr_sel = WR_DEC_SUB4;
      ST_EMIT: begin
        // advance the walk on the edge that loads the last copy
        cmd_o.load_pt = stat_i.out_free;
        cmd_o.step1   = stat_i.out_free && pt_last;
      end
      ST_STEP:  cmd_o.step2 = 1'b1;
      ST_FIN:   cmd_o.load_fin = stat_i.out_free;
      default:  in_ready_o = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

[design/mer_dp.sv]
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer datapath
// Radius registers, shared multiplier, walk state and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mer_dp (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   cfg_we_i,
  input  wire [mer_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  wire [mer_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  input  mer_pkg::mer_cmd_t                     cmd_i,
  output mer_pkg::mer_stat_t                    stat_o,
  input  wire                                   out_ready_i,
  output logic                                  out_valid_o,
  output logic signed [mer_pkg::PT_W-1:0]       point_x_o,
  output logic signed [mer_pkg::PT_W-1:0]       point_y_o,
  output logic                                  last_of_step_o,
  output logic                                  finished_o
);
  import mer_pkg::*;

  logic [COORD_BITS-1:0]   radius_a_q, radius_b_q;
  logic [COORD_BITS-1:0]   x_q, x_d, y_q, y_d;
  logic [SQ_W-1:0]         asq_q, asq_d, bsq_q, bsq_d;
  logic signed [GRAD_W-1:0] gx_q, gx_d, gy_q, gy_d;
  logic signed [DEC_W-1:0] dec_q, dec_d;
  logic                    r2_q, r2_d, done_q, done_d;
  logic [MUL_W-1:0]        t1_q, op_a, op_b;
  logic [SQ_W-1:0]         t2_q;
  logic [PROD_W-1:0]       prod_q;

  logic [COORD_BITS-1:0]   x_inc, y_dec, ty_abs;
  logic [COORD_BITS:0]     tx;
  logic signed [GRAD_W-1:0] bsq2_g, asq2_g, gy_init;
  logic signed [DEC_W-1:0] prod_e, prod4_e, bsq4_e, bsq_e, asq_e, gx_e, gy_e, term;
  logic                    dec_neg, dec_pos;

  logic                    out_valid_q;
  logic signed [PT_W-1:0]  px_q, py_q, px_n, py_n, pos_x, pos_y;
  logic                    last_q, fin_q;

  assign x_inc  = x_q + COORD_BITS'(1);
  assign y_dec  = y_q - COORD_BITS'(1);
  assign tx     = {x_q, 1'b1};
  assign ty_abs = (y_q == '0) ? COORD_BITS'(1) : y_dec;

  assign bsq2_g  = signed'({{(GRAD_W-SQ_W-1){1'b0}}, bsq_q, 1'b0});
  assign asq2_g  = signed'({{(GRAD_W-SQ_W-1){1'b0}}, asq_q, 1'b0});
  assign gy_init = signed'({prod_q[GRAD_W-2:0], 1'b0});
  assign prod_e  = signed'({{(DEC_W-PROD_W){1'b0}}, prod_q});
  assign prod4_e = signed'({{(DEC_W-PROD_W-2){1'b0}}, prod_q, 2'b00});
  assign bsq4_e  = signed'({{(DEC_W-SQ_W-2){1'b0}}, bsq_q, 2'b00});
  assign bsq_e   = signed'({{(DEC_W-SQ_W){1'b0}}, bsq_q});
  assign asq_e   = signed'({{(DEC_W-SQ_W){1'b0}}, asq_q});
  assign gx_e    = DEC_W'(gx_q);
  assign gy_e    = DEC_W'(gy_q);
  assign dec_neg = dec_q[DEC_W-1];
  assign dec_pos = !dec_q[DEC_W-1] && (dec_q != '0);

  // shared multiplier operand select
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_AA: begin
        op_a = MUL_W'(radius_a_q);
        op_b = MUL_W'(radius_a_q);
      end
      MUL_BB: begin
        op_a = MUL_W'(radius_b_q);
        op_b = MUL_W'(radius_b_q);
      end
      MUL_ASQ_B: begin
        op_a = MUL_W'(asq_q);
        op_b = MUL_W'(radius_b_q);
      end
      MUL_TX_TX: begin
        op_a = MUL_W'(tx);
        op_b = MUL_W'(tx);
      end
      MUL_TY_TY: begin
        op_a = MUL_W'(ty_abs);
        op_b = MUL_W'(ty_abs);
      end
      MUL_BSQ_T1: begin
        op_a = MUL_W'(bsq_q);
        op_b = t1_q;
      end
      MUL_ASQ_T2: begin
        op_a = MUL_W'(asq_q);
        op_b = MUL_W'(t2_q);
      end
      default: begin
        op_a = MUL_W'(asq_q);
        op_b = MUL_W'(bsq_q);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
    case (cmd_i.wr_sel)
      WR_T1:   t1_q <= prod_q[MUL_W-1:0];
      WR_T2:   t2_q <= prod_q[SQ_W-1:0];
      default: t1_q <= t1_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_a_q <= '0;
      radius_b_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RADIUS_A: radius_a_q <= cfg_data_i;
        CFG_RADIUS_B: radius_b_q <= cfg_data_i;
        default:      radius_a_q <= radius_a_q;
      endcase
    end
  end

  // walk state update
  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    asq_d  = asq_q;
    bsq_d  = bsq_q;
    gx_d   = gx_q;
    gy_d   = gy_q;
    dec_d  = dec_q;
    r2_d   = r2_q;
    done_d = done_q;
    term   = '0;
    case (cmd_i.wr_sel)
      WR_ASQ: asq_d = prod_q[SQ_W-1:0];
      WR_BSQ: bsq_d = prod_q[SQ_W-1:0];
      WR_INIT: begin
        x_d    = '0;
        y_d    = radius_b_q;
        gx_d   = '0;
        gy_d   = gy_init;
        dec_d  = bsq4_e - prod4_e + asq_e;
        r2_d   = 1'b0;
        done_d = 1'b0;
      end
      WR_DEC_SET:  dec_d = prod_e;
      WR_DEC_ADD4: dec_d = dec_q + prod4_e;
      WR_DEC_SUB4: begin
        dec_d = dec_q - prod4_e;
        r2_d  = 1'b1;
      end
      default: dec_d = dec_q;
    endcase

    if (cmd_i.step1) begin
      if (!r2_q) begin
        x_d  = x_inc;
        gx_d = gx_q + bsq2_g;
        if (!dec_neg) begin
          y_d  = y_dec;
          gy_d = gy_q - asq2_g;
        end
      end else if (y_q == '0) begin
        done_d = 1'b1;
      end else begin
        y_d  = y_dec;
        gy_d = gy_q - asq2_g;
        if (!dec_pos) begin
          x_d  = x_inc;
          gx_d = gx_q + bsq2_g;
        end
      end
    end

    // decision update uses the gradients already stepped
    if (cmd_i.step2 && !done_q) begin
      if (!r2_q) begin
        term = dec_neg ? (gx_e + bsq_e) : (gx_e - gy_e + bsq_e);
      end else begin
        term = dec_pos ? (asq_e - gy_e) : (gx_e - gy_e + asq_e);
      end
      dec_d = dec_q + signed'({term[DEC_W-3:0], 2'b00});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      y_q    <= '0;
      asq_q  <= '0;
      bsq_q  <= '0;
      gx_q   <= '0;
      gy_q   <= '0;
      dec_q  <= '0;
      r2_q   <= 1'b0;
      done_q <= 1'b1;
    end else begin
      x_q    <= x_d;
      y_q    <= y_d;
      asq_q  <= asq_d;
      bsq_q  <= bsq_d;
      gx_q   <= gx_d;
      gy_q   <= gy_d;
      dec_q  <= dec_d;
      r2_q   <= r2_d;
      done_q <= done_d;
    end
  end

  // mirrored copy select
  assign pos_x = signed'({1'b0, x_q});
  assign pos_y = signed'({1'b0, y_q});

  always_comb begin
    case (cmd_i.pt_idx)
      2'd0: begin
        px_n = pos_x;
        py_n = pos_y;
      end
      2'd1: begin
        px_n = (x_q == '0) ? pos_x : -pos_x;
        py_n = (x_q == '0) ? -pos_y : pos_y;
      end
      2'd2: begin
        px_n = pos_x;
        py_n = -pos_y;
      end
      default: begin
        px_n = -pos_x;
        py_n = -pos_y;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_pt || cmd_i.load_fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pt) begin
      px_q   <= px_n;
      py_q   <= py_n;
      last_q <= cmd_i.pt_last;
      fin_q  <= 1'b0;
    end else if (cmd_i.load_fin) begin
      px_q   <= '0;
      py_q   <= '0;
      last_q <= 1'b1;
      fin_q  <= 1'b1;
    end
  end

  assign stat_o.done          = done_q;
  assign stat_o.to_region_two = !r2_q && !(gx_q < gy_q);
  assign stat_o.pt_short      = (x_q == '0) || (y_q == '0);
  assign stat_o.out_free      = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign point_x_o      = px_q;
  assign point_y_o      = py_q;
  assign last_of_step_o = last_q;
  assign finished_o     = fin_q;

endmodule

`default_nettype wire

[design/midpoint_ellipse_rasterizer.sv]
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer
// Two-region midpoint walk of an origin-centered ellipse, one position per request.
// ----------------------------------------------------------------------------
// Each request emits the mirrored copies of the current walk point (two on an
// axis, else four) and then steps the walk; once the walk is over every request
// returns one finished result until a request with restart reloads the walk from
// the radius registers. Radii written on the config port take effect at the next
// restart. A request is taken in ST_IDLE; a restart then runs the shared
// multiplier through ST_R0 to ST_R3 and ST_CHECK; a request that crosses into
// region two runs it through ST_W0 to ST_W5. Results load in ST_EMIT, which
// holds while the result channel stalls, ST_STEP updates the decision term and
// a finished request loads its result in ST_FIN. The result register lets the
// next request be taken while the last result of the previous one still waits.
`default_nettype none

module midpoint_ellipse_rasterizer (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire [mer_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [mer_pkg::CFG_DATA_W-1:0] cfg_data_i,
  mer_in_if.sink                        req_i,
  mer_out_if.source                     res_o
);
  import mer_pkg::*;

  `include "midpoint_ellipse_rasterizer_assert.svh"

  mer_cmd_t  cmd;
  mer_stat_t stat;
  logic      in_ready;

  assign req_i.ready = in_ready;

  mer_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .restart_i  (req_i.restart),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mer_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_ready_i    (res_o.ready),
    .out_valid_o    (res_o.valid),
    .point_x_o      (res_o.point_x),
    .point_y_o      (res_o.point_y),
    .last_of_step_o (res_o.last_of_step),
    .finished_o     (res_o.finished)
  );

  `MER_ASSERT_IMPL(a_fin_zero, res_o.valid && res_o.finished, (res_o.point_x == '0) && (res_o.point_y == '0) && res_o.last_of_step)
  `MER_ASSERT_IMPL(a_fin_when_done, cmd.load_fin, stat.done && stat.out_free)
  `MER_ASSERT_IMPL(a_pt_slot_free, cmd.load_pt, stat.out_free && !stat.done)
  `MER_ASSERT_NEXT(a_restart_live, cmd.wr_sel == WR_INIT, !stat.done)

endmodule

`default_nettype wire

[sim/midpoint_ellipse_rasterizer_test.sv]
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer testbench
// Sends restart and continue requests over many radius settings, with bursty
// requests and a stalling result sink. Each point is checked against a local
// model of the integer two-region walk.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mer_pkg::*;

  typedef struct packed {
    logic signed [PT_W-1:0] px;
    logic signed [PT_W-1:0] py;
    logic                   last;
    logic                   fin;
  } point_t;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SLOW, SINK_BUSY} sink_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  mer_in_if  req_if ();
  mer_out_if res_if ();

  midpoint_ellipse_rasterizer u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Walk state as the block should hold it.
  logic [CFG_DATA_W-1:0]  radius_a_reg = '0;
  logic [CFG_DATA_W-1:0]  radius_b_reg = '0;
  logic [COORD_BITS-1:0]  walk_x = '0;
  logic [COORD_BITS-1:0]  walk_y = '0;
  longint                 walk_asq = 0;
  longint                 walk_bsq = 0;
  longint                 walk_gx = 0;
  longint                 walk_gy = 0;
  longint                 walk_dec = 0;
  bit                     walk_region_two = 1'b0;
  bit                     walk_done = 1'b1;

  point_t      expected_points[$];
  int unsigned errors = 0;
  int unsigned requests_sent = 0;
  int unsigned points_checked = 0;
  int unsigned finished_seen = 0;
  int unsigned settings_used = 0;
  int unsigned burst_left = 0;
  bit          steady_sender = 1'b0;

  function automatic void queue_point(longint px, longint py, bit last, bit fin);
    point_t p;
    p.px   = px[PT_W-1:0];
    p.py   = py[PT_W-1:0];
    p.last = last;
    p.fin  = fin;
    expected_points.push_back(p);
  endfunction

  // Emit the mirrored copies of the current point, then take one walk step.
  function automatic void advance_walk(bit restart);
    longint px, py, tx, ty;
    if (restart) begin
      walk_asq        = longint'(radius_a_reg) * longint'(radius_a_reg);
      walk_bsq        = longint'(radius_b_reg) * longint'(radius_b_reg);
      walk_x          = '0;
      walk_y          = radius_b_reg;
      walk_gx         = 0;
      walk_gy         = 2 * walk_asq * longint'(radius_b_reg);
      walk_dec        = 4 * walk_bsq - 4 * walk_asq * longint'(radius_b_reg) + walk_asq;
      walk_region_two = 1'b0;
      walk_done       = 1'b0;
    end
    if (walk_done) begin
      queue_point(0, 0, 1'b1, 1'b1);
      return;
    end
    if (!walk_region_two && !(walk_gx < walk_gy)) begin
      tx = 2 * longint'(walk_x) + 1;
      ty = longint'(walk_y) - 1;
      walk_dec = walk_bsq * tx * tx + 4 * walk_asq * ty * ty - 4 * walk_asq * walk_bsq;
      walk_region_two = 1'b1;
    end
    px = longint'(walk_x);
    py = longint'(walk_y);
    if (px == 0) begin
      queue_point(px, py, 1'b0, 1'b0);
      queue_point(px, -py, 1'b1, 1'b0);
    end else if (py == 0) begin
      queue_point(px, py, 1'b0, 1'b0);
      queue_point(-px, py, 1'b1, 1'b0);
    end else begin
      queue_point(px, py, 1'b0, 1'b0);
      queue_point(-px, py, 1'b0, 1'b0);
      queue_point(px, -py, 1'b0, 1'b0);
      queue_point(-px, -py, 1'b1, 1'b0);
    end
    if (!walk_region_two) begin
      walk_x  = walk_x + COORD_BITS'(1);
      walk_gx += 2 * walk_bsq;
      if (walk_dec < 0) begin
        walk_dec += 4 * (walk_gx + walk_bsq);
      end else begin
        walk_y   = walk_y - COORD_BITS'(1);
        walk_gy  -= 2 * walk_asq;
        walk_dec += 4 * (walk_gx - walk_gy + walk_bsq);
      end
    end else if (walk_y == 0) begin
      walk_done = 1'b1;
    end else begin
      walk_y  = walk_y - COORD_BITS'(1);
      walk_gy -= 2 * walk_asq;
      if (walk_dec > 0) begin
        walk_dec += 4 * (walk_asq - walk_gy);
      end else begin
        walk_x   = walk_x + COORD_BITS'(1);
        walk_gx  += 2 * walk_bsq;
        walk_dec += 4 * (walk_gx - walk_gy + walk_asq);
      end
    end
  endfunction

  task automatic send_request(input bit restart);
    int unsigned gap;
    if (burst_left == 0 && !steady_sender) begin
      gap = $urandom_range(1, 6);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    req_if.valid   <= 1'b1;
    req_if.restart <= restart;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    advance_walk(restart);
    requests_sent++;
    if (burst_left > 0) burst_left--;
  endtask

  // Drop the request line and wait until every expected point is back.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_radii(input logic [CFG_DATA_W-1:0] a, input logic [CFG_DATA_W-1:0] b);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_RADIUS_A;
    cfg_data <= a;
    @(posedge clk_i);
    radius_a_reg = a;
    cfg_idx  <= CFG_RADIUS_B;
    cfg_data <= b;
    @(posedge clk_i);
    radius_b_reg = b;
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic walk_on(input int unsigned max_items);
    int unsigned n;
    n = 0;
    while (!walk_done && n < max_items) begin
      send_request(1'b0);
      n++;
    end
  endtask

  // Out of reset the walk is over; zero radii give a single on-axis point.
  task automatic test_reset_state();
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    drain_results();
  endtask

  task automatic test_extreme_radii();
    set_radii(10'd1023, 10'd1023);
    send_request(1'b1);
    walk_on(4);
    // restart in the middle of a walk
    send_request(1'b1);
    walk_on(1);
    drain_results();
    set_radii(10'd1023, 10'd0);
    send_request(1'b1);
    walk_on(2);
    send_request(1'b0);
    drain_results();
    set_radii(10'd0, 10'd1023);
    send_request(1'b1);
    walk_on(3);
    drain_results();
  endtask

  // Complete walks through both regions and on into the finished state.
  task automatic test_small_walks();
    set_radii(10'd1, 10'd1);
    send_request(1'b1);
    walk_on(50);
    send_request(1'b0);
    drain_results();
    set_radii(10'd5, 10'd2);
    send_request(1'b1);
    walk_on(50);
    drain_results();
  endtask

  task automatic test_random_walks();
    int unsigned first, pick, cap, n;
    first = requests_sent;
    while (requests_sent - first < 500) begin
      steady_sender = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) != 0) begin
        drain_results();
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          set_radii(CFG_DATA_W'($urandom_range(0, 12)), CFG_DATA_W'($urandom_range(0, 12)));
        end else if (pick < 90) begin
          set_radii(CFG_DATA_W'($urandom_range(0, 40)), CFG_DATA_W'($urandom_range(0, 40)));
        end else if (pick < 97) begin
          if ($urandom_range(0, 1)) begin
            set_radii(CFG_DATA_W'($urandom_range(0, 1023)),
                      CFG_DATA_W'($urandom_range(0, 6)));
          end else begin
            set_radii(CFG_DATA_W'($urandom_range(0, 6)),
                      CFG_DATA_W'($urandom_range(0, 1023)));
          end
        end else begin
          set_radii(CFG_DATA_W'($urandom_range(0, 1) * 1023),
                    CFG_DATA_W'($urandom_range(0, 1) * 1023));
        end
      end
      // keep walks over large radii short
      cap = (radius_a_reg > 40 || radius_b_reg > 40) ? 30 : 400;
      if ($urandom_range(0, 7) == 0) cap = $urandom_range(1, 20);
      send_request(1'b1);
      n = 0;
      while (!walk_done && n < cap) begin
        if ($urandom_range(0, 29) == 0) begin
          // new radii must not disturb the running walk
          drain_results();
          set_radii(CFG_DATA_W'($urandom_range(0, 1023)),
                    CFG_DATA_W'($urandom_range(0, 1023)));
        end
        send_request($urandom_range(0, 39) == 0);
        n++;
      end
      repeat ($urandom_range(0, 2)) send_request(1'b0);
    end
    steady_sender = 1'b0;
  endtask

  // Result sink: check each accepted point and stall on a changing pattern.
  initial begin
    point_t      want;
    sink_mode_e  mode;
    int unsigned mode_left, phase;
    bit          rdy;
    mode_left = 0;
    phase = 0;
    mode = SINK_OPEN;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        if (expected_points.size() == 0) begin
          $error("unexpected result: point_x %0d point_y %0d", res_if.point_x,
                 res_if.point_y);
          errors++;
        end else begin
          want = expected_points.pop_front();
          if (res_if.point_x !== want.px) begin
            $error("point_x: expected %0d, got %0d", want.px, res_if.point_x);
            errors++;
          end
          if (res_if.point_y !== want.py) begin
            $error("point_y: expected %0d, got %0d", want.py, res_if.point_y);
            errors++;
          end
          if (res_if.last_of_step !== want.last) begin
            $error("last_of_step: expected %0d, got %0d", want.last, res_if.last_of_step);
            errors++;
          end
          if (res_if.finished !== want.fin) begin
            $error("finished: expected %0d, got %0d", want.fin, res_if.finished);
            errors++;
          end
          points_checked++;
          if (want.fin) finished_seen++;
        end
      end
      if (mode_left == 0) begin
        mode = sink_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 256);
      end
      mode_left--;
      phase++;
      case (mode)
        SINK_OPEN: rdy = 1'b1;
        SINK_COIN: rdy = 1'($urandom_range(0, 1));
        SINK_SLOW: rdy = (phase % 4 == 0);
        default:   rdy = ($urandom_range(0, 7) != 0);
      endcase
      res_if.ready <= rdy;
    end
  end

  initial begin
    req_if.valid   <= 1'b0;
    req_if.restart <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_idx        <= CFG_RADIUS_A;
    cfg_data       <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_extreme_radii();
    test_small_walks();
    test_random_walks();
    drain_results();
    $display("Sent %0d requests over %0d radius settings; checked %0d results,",
             requests_sent, settings_used, points_checked);
    $display("%0d of them finished markers.", finished_seen);
    if (errors == 0) begin
      $display("midpoint_ellipse_rasterizer_test passed");
    end else begin
      $display("midpoint_ellipse_rasterizer_test failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("midpoint_ellipse_rasterizer_test failed");
    $finish;
  end

endmodule
